// ===== src/rcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrs_pkg
// Shared types and constants for the relative change ratio statistics block.
// ----------------------------------------------------------------------------
package rcrs_pkg;

    localparam int unsigned MAX_LEN  = 65536;
    localparam int unsigned CNT_W    = 17;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned RATIO_W  = 32;
    localparam int unsigned DIV_STEPS = 48;
    localparam int unsigned STEP_W   = 6;

    // One-hot controller states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RDIV  = 5'b00010,
        S_ACC   = 5'b00100,
        S_MDIV  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;       // Capture the input item and start the ratio divide.
        logic div_step;   // One restoring-divide step.
        logic acc;        // Fold the ratio into the running statistics.
        logic mean_start; // Load the mean divide.
        logic emit;       // Present the result and clear the statistics.
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic is_last;
    } t_status;

endpackage

// ===== src/rcrs_datapath.sv =====
// ----------------------------------------------------------------------------
// rcrs_datapath
// Shared serial divider, running statistics and the result register.
// ----------------------------------------------------------------------------
module rcrs_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rcrs_pkg::t_cmd        i_cmd,
    output rcrs_pkg::t_status     o_status,
    input  logic [31:0]           i_x,
    input  logic [31:0]           i_d,
    input  logic                  i_last,
    output logic [131:0]          o_result
);
    import rcrs_pkg::*;

    logic [31:0]        r_hi, n_hi;
    logic [CNT_W-1:0]   r_hi_idx, n_hi_idx;
    logic [31:0]        r_lo, n_lo;
    logic [CNT_W-1:0]   r_lo_idx, n_lo_idx;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic               r_last;
    logic [SUM_W-1:0]   r_quo;
    logic [SUM_W:0]     r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [STEP_W-1:0]  r_step;
    logic [131:0]       r_result;

    logic [31:0]        w_ax, w_ad;
    logic [SUM_W:0]     w_trial;
    logic [SUM_W:0]     w_sub;
    logic [31:0]        w_r, w_mean;
    logic [SUM_W:0]     w_sum_ext;
    logic [CNT_W-1:0]   w_pos;
    logic               w_sat;

    assign w_ax = i_x[31] ? (~i_x + 32'd1) : i_x;
    assign w_ad = i_d[31] ? (~i_d + 32'd1) : i_d;

    assign w_trial = {r_rem[SUM_W-1:0], r_quo[SUM_W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign w_r     = r_quo[31:0];
    assign w_mean  = (r_quo[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF : r_quo[31:0];

    assign w_sat     = (r_cnt == CNT_W'(MAX_LEN));
    assign w_pos     = w_sat ? r_cnt : r_cnt + CNT_W'(1);
    assign w_sum_ext = {1'b0, r_sum} + {{(SUM_W-31){1'b0}}, w_r};

    always_comb begin
        n_hi = r_hi; n_hi_idx = r_hi_idx; n_lo = r_lo; n_lo_idx = r_lo_idx;
        n_sum = r_sum; n_cnt = r_cnt; n_ovf = r_ovf;
        if (i_cmd.acc) begin
            n_cnt = w_pos;
            if (w_sat) begin
                n_ovf = 1'b1;
            end
            if (w_r > r_hi) begin
                n_hi = w_r; n_hi_idx = w_pos;
            end
            if (w_r < r_lo) begin
                n_lo = w_r; n_lo_idx = w_pos;
            end
            n_sum = w_sum_ext[SUM_W] ? {SUM_W{1'b1}} : w_sum_ext[SUM_W-1:0];
        end
        if (i_cmd.emit) begin
            n_hi = '0; n_hi_idx = '0; n_lo = '1; n_lo_idx = '0;
            n_sum = '0; n_cnt = '0; n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0; r_hi_idx <= '0; r_lo <= '1; r_lo_idx <= '0;
            r_sum <= '0; r_cnt <= '0; r_ovf <= 1'b0;
            r_step <= '0;
        end else begin
            r_hi <= n_hi; r_hi_idx <= n_hi_idx; r_lo <= n_lo; r_lo_idx <= n_lo_idx;
            r_sum <= n_sum; r_cnt <= n_cnt; r_ovf <= n_ovf;
            if (i_cmd.load || i_cmd.mean_start) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo  <= {w_ad, 16'd0};
            r_rem  <= '0;
            r_den  <= {16'd0, w_ax} + SUM_W'(65536);
            r_last <= i_last;
        end else if (i_cmd.mean_start) begin
            r_quo <= n_sum;
            r_rem <= '0;
            r_den <= {{(SUM_W-CNT_W){1'b0}}, n_cnt};
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ~w_sub[SUM_W]};
            r_rem <= w_sub[SUM_W] ? w_trial : w_sub;
        end
        if (i_cmd.emit) begin
            r_result <= {1'b0, r_ovf, w_mean, r_lo_idx, r_lo, r_hi_idx, r_hi};
        end
    end

    assign o_status.div_done = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_status.is_last  = r_last;
    assign o_result = r_result;

endmodule

// ===== src/rcrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcrs_ctrl
// Sequencer for ratio divide, accumulation, mean divide and result handshake.
// ----------------------------------------------------------------------------
module rcrs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  rcrs_pkg::t_status     i_status,
    output rcrs_pkg::t_cmd        o_cmd
);
    import rcrs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        o_in_ready = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_status.is_last ? S_MDIV : S_IDLE;
                o_cmd.mean_start = i_status.is_last;
            end
            S_MDIV: begin
                if (i_status.div_done && !n_out_valid) begin
                    o_cmd.div_step = 1'b1;
                    n_state = S_OUT;
                end else if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/relative_change_ratio_stats_core.sv =====
// ----------------------------------------------------------------------------
// relative_change_ratio_stats_core
// Running max, min and mean of |d|/(1+|x|) with positions, per vector.
// ----------------------------------------------------------------------------
// Each element takes one load, 48 steps of the shared serial divider and
// one accumulate. The last element adds a 48-step mean divide and then
// registers the result. The final mean-divide step waits until the previous
// result has been taken. Reset is synchronous and active low, and clears
// the statistics and the handshake state.
module relative_change_ratio_stats_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // x_value, d_value
    input  logic         s_axis_tlast,  // last_element
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata   // max_ratio, max_position, min_ratio,
                                        // min_position, mean_ratio,
                                        // length_overflow, zero fill
);
    import rcrs_pkg::*;

    t_cmd         w_cmd;
    t_status      w_status;
    logic [131:0] w_result;

    rcrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rcrs_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_x      (s_axis_tdata[31:0]),
        .i_d      (s_axis_tdata[63:32]),
        .i_last   (s_axis_tlast),
        .o_result (w_result)
    );

    assign m_axis_tdata = {4'd0, w_result};

endmodule

// ===== tb/sv/relative_change_ratio_stats_core_tb.sv =====
// ----------------------------------------------------------------------------
// relative_change_ratio_stats_core_tb
// Streams vectors of (x, d) pairs into the statistics core and compares each
// result transfer, field by field, against an in-bench prediction of the
// max, min, mean, positions and overflow flag.
// ----------------------------------------------------------------------------
module relative_change_ratio_stats_core_tb;
    import rcrs_pkg::*;

    typedef struct packed {
        logic        ovf;
        logic [31:0] mean_ratio;
        logic [16:0] min_pos;
        logic [31:0] min_ratio;
        logic [16:0] max_pos;
        logic [31:0] max_ratio;
    } t_stats;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;  // x_value, d_value
    logic         s_axis_tlast = 1'b0; // last_element
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;       // max_ratio, max_position, min_ratio,
                                      // min_position, mean_ratio, overflow

    t_stats      stats_due_q[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;
    bit          gaps_on = 1'b1;
    logic [31:0] hi_r, lo_r;
    logic [16:0] hi_i, lo_i, cnt;
    logic [47:0] sum_r;
    bit          ovf_r;

    relative_change_ratio_stats_core u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [32:0] mag32(logic [31:0] v);
        return v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    task automatic clear_stats();
        hi_r = '0; hi_i = '0; lo_r = '1; lo_i = '0;
        sum_r = '0; cnt = '0; ovf_r = 1'b0;
    endtask

    task automatic predict_element(logic [31:0] x, logic [31:0] d, bit last);
        logic [63:0] q;
        logic [48:0] s;
        logic [47:0] m;
        t_stats      st;
        q = ({31'd0, mag32(d)} << 16) / (64'd65536 + {31'd0, mag32(x)});
        if (cnt >= MAX_LEN) begin
            cnt = CNT_W'(MAX_LEN);
            ovf_r = 1'b1;
        end else begin
            cnt = cnt + 17'd1;
        end
        if (q[31:0] > hi_r) begin
            hi_r = q[31:0]; hi_i = cnt;
        end
        if (q[31:0] < lo_r) begin
            lo_r = q[31:0]; lo_i = cnt;
        end
        s = {1'b0, sum_r} + {17'd0, q[31:0]};
        sum_r = s[48] ? '1 : s[47:0];
        if (last) begin
            m = sum_r / {31'd0, cnt};
            st.max_ratio = hi_r; st.max_pos = hi_i;
            st.min_ratio = lo_r; st.min_pos = lo_i;
            st.mean_ratio = (m > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
            st.ovf = ovf_r;
            stats_due_q.push_back(st);
            clear_stats();
        end
    endtask

    task automatic send_element(logic [31:0] x, logic [31:0] d, bit last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {d, x};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_element(x, d, last);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vector(int len);
        for (int k = 1; k <= len; k++)
            send_element(rand_q(), rand_q(), k == len);
    endtask

    task automatic test_extremes();
        send_element(32'h0, 32'h0, 1'b1);
        send_element(32'h0, 32'h8000_0000, 1'b1);
        send_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_element(32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
        send_element(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        send_element(32'h0, 32'h0, 1'b1);
        send_element(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_element(32'h0, 32'h8000_0000, 1'b0);
        send_element(32'h0, 32'h8000_0000, 1'b1);
    endtask

    task automatic test_ties_and_zeros();
        for (int k = 0; k < 4; k++) send_element(32'h0, 32'h0, k == 3);
        for (int k = 0; k < 4; k++) send_element(32'h0002_0000, 32'h0003_0000, k == 3);
        send_element(32'h0, 32'h0001_0000, 1'b0);
        send_element(32'h0, 32'h0, 1'b0);
        send_element(32'h0, 32'h0005_0000, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int v = 0; v < 6; v++) send_vector(3);
        join
    endtask

    task automatic test_random();
        int n;
        n = 0;
        while (n < 1020) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(1, 8);
            gaps_on = $urandom_range(0, 4) != 0;
            send_vector(len);
            n += len;
        end
        gaps_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 9) < 6) || cycles[9];
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd4_000_000) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_stats got;
            t_stats want;
            got = m_axis_tdata[130:0];
            if (stats_due_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = stats_due_q.pop_front();
                if (got.max_ratio !== want.max_ratio) begin
                    errors++;
                    $display("%0t: max_ratio exp %h got %h", $time,
                             want.max_ratio, got.max_ratio);
                end
                if (got.max_pos !== want.max_pos) begin
                    errors++;
                    $display("%0t: max_pos exp %0d got %0d", $time,
                             want.max_pos, got.max_pos);
                end
                if (got.min_ratio !== want.min_ratio) begin
                    errors++;
                    $display("%0t: min_ratio exp %h got %h", $time,
                             want.min_ratio, got.min_ratio);
                end
                if (got.min_pos !== want.min_pos) begin
                    errors++;
                    $display("%0t: min_pos exp %0d got %0d", $time,
                             want.min_pos, got.min_pos);
                end
                if (got.mean_ratio !== want.mean_ratio) begin
                    errors++;
                    $display("%0t: mean_ratio exp %h got %h", $time,
                             want.mean_ratio, got.mean_ratio);
                end
                if (got.ovf !== want.ovf) begin
                    errors++;
                    $display("%0t: overflow exp %b got %b", $time,
                             want.ovf, got.ovf);
                end
            end
        end
    end

    initial begin
        clear_stats();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_ties_and_zeros();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (stats_due_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && stats_due_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== relative_change_ratio_stats_core.f =====
src/rcrs_pkg.sv
src/rcrs_datapath.sv
src/rcrs_ctrl.sv
src/relative_change_ratio_stats_core.sv
tb/sv/relative_change_ratio_stats_core_tb.sv
